// ===== src/ripemd160_hash_engine_macros.svh =====
// Assertion macros for the checker file of the hash engine.
// No dependencies.
`ifndef RIPEMD160_HASH_ENGINE_MACROS_SVH
`define RIPEMD160_HASH_ENGINE_MACROS_SVH

// Same-cycle implication, gated by the active-low reset.
`define RHE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, gated by the active-low reset.
`define RHE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/rhe_pkg.sv =====
// Types, constants and step functions of the RIPEMD-160 hash engine.
// No dependencies.
package rhe_pkg;

	typedef logic [31:0] word_t;

	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  valid_bytes;
		logic        end_of_message;
	} msg_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} dig_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
		word_t e;
	} line_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BYTES,
		ST_PADM,
		ST_PADZ,
		ST_PADL,
		ST_PRE,
		ST_COMP,
		ST_FIN,
		ST_OUT
	} state_t;

	localparam int unsigned NUM_STEPS  = 80;
	localparam logic [6:0]  LAST_STEP  = 7'd79;
	localparam logic [5:0]  LEN_FILL   = 6'd56;
	localparam logic [5:0]  FULL_FILL  = 6'd63;
	localparam logic [2:0]  LAST_INDEX = 3'd4;
	localparam logic [7:0]  PAD_MARK   = 8'h80;

	localparam word_t IV [0:4] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};
	localparam word_t KL [0:4] = '{
		32'h00000000, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hA953FD4E
	};
	localparam word_t KR [0:4] = '{
		32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3, 32'h7A6D76E9, 32'h00000000
	};

	localparam logic [3:0] SEL_L [0:NUM_STEPS-1] = '{
		0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,
		7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
		3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12,
		1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2,
		4,0,5,9,7,12,2,10,14,1,3,8,11,6,15,13
	};
	localparam logic [3:0] SEL_R [0:NUM_STEPS-1] = '{
		5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12,
		6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
		15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13,
		8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14,
		12,15,10,4,1,5,8,7,6,2,13,14,0,3,9,11
	};
	localparam logic [4:0] ROT_L [0:NUM_STEPS-1] = '{
		11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8,
		7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
		11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5,
		11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12,
		9,15,5,11,6,8,13,12,5,12,13,14,11,8,5,6
	};
	localparam logic [4:0] ROT_R [0:NUM_STEPS-1] = '{
		8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6,
		9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
		9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5,
		15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8,
		8,5,12,9,12,5,14,6,8,13,6,5,15,13,11,11
	};

	function automatic word_t rotl(word_t x, logic [4:0] n);
		return (x << n) | (x >> (6'd32 - {1'b0, n}));
	endfunction

	function automatic word_t round_fn(logic [2:0] r, word_t x, word_t y, word_t z);
		word_t f;
		case (r)
			3'd0: f = x ^ y ^ z;
			3'd1: f = (x & y) | (~x & z);
			3'd2: f = (x | ~y) ^ z;
			3'd3: f = (x & z) | (y & ~z);
			default: f = x ^ (y | ~z);
		endcase
		return f;
	endfunction

	function automatic line_t line_step(line_t v, logic [2:0] r, word_t w, word_t k,
			logic [4:0] s);
		line_t o;
		o.b = rotl(v.a + round_fn(r, v.b, v.c, v.d) + w + k, s) + v.e;
		o.a = v.e;
		o.e = v.d;
		o.d = rotl(v.c, 5'd10);
		o.c = v.b;
		return o;
	endfunction

endpackage

// ===== src/ripemd160_hash_engine.sv =====
// RIPEMD-160 hash engine: byte packer, 16-word block memory, dual-line compressor.
// Depends on rhe_pkg.
//
// Usage:
//   msg channel (msg_valid/msg_ready/msg) takes the message as 32-bit words,
//   earliest byte in bits 7:0, with a count of valid low bytes (above four
//   counts as four). end_of_message marks the final word, which may be partial
//   or empty.
//   dig channel (dig_valid/dig_ready/dig) returns the five chaining words of
//   the digest, word_index 0 first, last_word set on the fifth.
// Timing:
//   A word is taken in the idle state, its valid bytes are then written into
//   the block memory in turn, and a closing state ends the word; no new word
//   is taken before that. Each completed 64-byte block adds a prefetch, 80
//   steps (one step of both lines per cycle, set by the two-port block memory
//   read) and a chaining update. The final word adds the padding and length
//   bytes, the end of the zero fill, and one or two compressions; then the
//   digest is offered one word per cycle while dig_ready is high.
// Reset: chaining value returns to the initial vector, counters clear, the
//   engine waits in idle. A stalled receiver holds the current digest transfer
//   and the engine takes no new word until all five transfers are done; the
//   chaining value reloads the initial vector on the fifth transfer.
module ripemd160_hash_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          msg_valid,
	output logic          msg_ready,
	input  rhe_pkg::msg_t msg,
	output logic          dig_valid,
	input  logic          dig_ready,
	output rhe_pkg::dig_t dig
);
	import rhe_pkg::*;

	// control
	state_t      state_q, state_d;
	state_t      ret_q, ret_d;
	logic        push_en;
	logic [7:0]  push_byte;

	// input word and counters
	word_t       word_q;
	logic [2:0]  cnt_q;
	logic        last_q;
	logic [2:0]  bi_q;
	logic [2:0]  len_q;
	logic [5:0]  fill_q;
	logic [60:0] byte_total_q;
	logic [63:0] len_bits;
	logic [2:0]  oidx_q;
	logic [6:0]  step_q;
	logic [6:0]  rd_step;

	// block memory: byte writes, two sync read ports
	word_t       blk_mem [0:15];
	word_t       mem_l_q, mem_r_q;

	// working lines and chaining value
	line_t       left_q, right_q;
	word_t       chain_q [0:4];
	logic [2:0]  rnd;

	assign len_bits = {byte_total_q, 3'b000};
	assign rnd      = step_q[6:4];
	// read address of the step after the current one; prefetch reads step 0
	assign rd_step  = (state_q == ST_PRE || step_q == LAST_STEP) ? 7'd0 : 7'(step_q + 7'd1);

	always_comb begin
		state_d   = state_q;
		ret_d     = ret_q;
		push_en   = 1'b0;
		push_byte = 8'h00;
		msg_ready = 1'b0;
		dig_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				msg_ready = 1'b1;
				if (msg_valid) state_d = ST_BYTES;
			end
			ST_BYTES: begin
				if (bi_q == cnt_q) begin
					state_d = last_q ? ST_PADM : ST_IDLE;
				end else begin
					push_en   = 1'b1;
					push_byte = word_q[{bi_q[1:0], 3'b000} +: 8];
				end
			end
			ST_PADM: begin
				push_en   = 1'b1;
				push_byte = PAD_MARK;
				state_d   = ST_PADZ;
			end
			ST_PADZ: begin
				if (fill_q == LEN_FILL) state_d = ST_PADL;
				else push_en = 1'b1;
			end
			ST_PADL: begin
				push_en   = 1'b1;
				push_byte = len_bits[{len_q, 3'b000} +: 8];
				if (len_q == 3'd7) state_d = ST_OUT;
			end
			ST_PRE: state_d = ST_COMP;
			ST_COMP: begin
				if (step_q == LAST_STEP) state_d = ST_FIN;
			end
			ST_FIN: state_d = ret_q;
			ST_OUT: begin
				dig_valid = 1'b1;
				if (dig_ready && oidx_q == LAST_INDEX) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		// a byte that fills the block detours through compression
		if (push_en && fill_q == FULL_FILL) begin
			ret_d   = state_d;
			state_d = ST_PRE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	// block memory
	always_ff @(posedge clk) begin
		if (push_en) blk_mem[fill_q[5:2]][{fill_q[1:0], 3'b000} +: 8] <= push_byte;
		mem_l_q <= blk_mem[SEL_L[rd_step]];
		mem_r_q <= blk_mem[SEL_R[rd_step]];
	end

	// counters and chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bi_q         <= '0;
			cnt_q        <= '0;
			last_q       <= 1'b0;
			len_q        <= '0;
			fill_q       <= '0;
			byte_total_q <= '0;
			oidx_q       <= '0;
			step_q       <= '0;
			for (int i = 0; i < 5; i++) chain_q[i] <= IV[i];
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (msg_valid) begin
						cnt_q        <= (msg.valid_bytes > 3'd4) ? 3'd4 : msg.valid_bytes;
						last_q       <= msg.end_of_message;
						bi_q         <= '0;
						byte_total_q <= byte_total_q + ((msg.valid_bytes > 3'd4) ?
							61'd4 : {58'd0, msg.valid_bytes});
					end
				end
				ST_BYTES: begin
					if (push_en) bi_q <= 3'(bi_q + 3'd1);
				end
				ST_PADM: len_q <= '0;
				ST_PADL: len_q <= 3'(len_q + 3'd1);
				ST_PRE:  step_q <= '0;
				ST_COMP: step_q <= (step_q == LAST_STEP) ? 7'd0 : 7'(step_q + 7'd1);
				ST_FIN: begin
					chain_q[0] <= chain_q[1] + left_q.c + right_q.d;
					chain_q[1] <= chain_q[2] + left_q.d + right_q.e;
					chain_q[2] <= chain_q[3] + left_q.e + right_q.a;
					chain_q[3] <= chain_q[4] + left_q.a + right_q.b;
					chain_q[4] <= chain_q[0] + left_q.b + right_q.c;
				end
				ST_OUT: begin
					if (dig_ready) begin
						if (oidx_q == LAST_INDEX) begin
							oidx_q       <= '0;
							byte_total_q <= '0;
							for (int i = 0; i < 5; i++) chain_q[i] <= IV[i];
						end else begin
							oidx_q <= 3'(oidx_q + 3'd1);
						end
					end
				end
				default: ;
			endcase
			if (push_en) fill_q <= 6'(fill_q + 6'd1);
		end
	end

	// input word and working lines
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && msg_valid) word_q <= msg.data_word;
		if (state_q == ST_PRE) begin
			left_q  <= '{chain_q[0], chain_q[1], chain_q[2], chain_q[3], chain_q[4]};
			right_q <= '{chain_q[0], chain_q[1], chain_q[2], chain_q[3], chain_q[4]};
		end else if (state_q == ST_COMP) begin
			left_q  <= line_step(left_q, rnd, mem_l_q, KL[rnd], ROT_L[step_q]);
			right_q <= line_step(right_q, 3'(3'd4 - rnd), mem_r_q, KR[rnd], ROT_R[step_q]);
		end
	end

	assign dig.digest_word = chain_q[oidx_q];
	assign dig.word_index  = oidx_q;
	assign dig.last_word   = (oidx_q == LAST_INDEX);

endmodule

// ===== src/rhe_checker.sv =====
// Port-level checker for the RIPEMD-160 hash engine, bound to the top level.
// Depends on rhe_pkg and ripemd160_hash_engine_macros.svh.
`include "ripemd160_hash_engine_macros.svh"

module rhe_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          msg_ready,
	input logic          dig_valid,
	input logic          dig_ready,
	input rhe_pkg::dig_t dig
);
	import rhe_pkg::*;

	`RHE_ASSERT_NXT(a_dig_hold, clk, arst_n, dig_valid && !dig_ready, dig_valid && $stable(dig), "digest transfer dropped or changed while stalled")
	`RHE_ASSERT_NOW(a_last_flag, clk, arst_n, dig_valid, dig.last_word == (dig.word_index == LAST_INDEX), "last_word does not match word_index")
	`RHE_ASSERT_NXT(a_index_seq, clk, arst_n, dig_valid && dig_ready && !dig.last_word, dig_valid && dig.word_index == 3'($past(dig.word_index) + 3'd1), "digest words out of sequence")
	`RHE_ASSERT_NOW(a_no_overlap, clk, arst_n, dig_valid, !msg_ready, "message accepted while digest pending")

endmodule

bind ripemd160_hash_engine rhe_checker u_rhe_checker (.*);
